>>> hdl/rrr_pkg.sv
`default_nettype none
package rrr_pkg;

  localparam int unsigned HEADER_BYTES = 8;
  localparam int unsigned ALIGN_BYTES  = 8;
  localparam int unsigned MIN_CAP_LOG2 = 6;
  localparam int unsigned RESQ_DEPTH   = 4;
  localparam int unsigned RESQ_AW      = $clog2(RESQ_DEPTH);
  localparam int unsigned PADDR_W      = 5;
  localparam int unsigned PDATA_W      = 64;

  typedef enum logic [2:0] {
    ST_RECORD    = 3'd0,
    ST_PAD       = 3'd1,
    ST_TOO_LARGE = 3'd2,
    ST_FULL      = 3'd3,
    ST_PUBLISHED = 3'd4
  } status_t;

  typedef enum logic {
    KIND_RESERVE = 1'b0,
    KIND_PUBLISH = 1'b1
  } item_kind_t;

  typedef enum logic [1:0] {
    REG_CAPACITY_LOG2   = 2'd0,
    REG_START_CURSOR    = 2'd1,
    REG_PAD_FLAG_MASK   = 2'd2,
    REG_PAD_RECORD_KIND = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [4:0]  capacity_log2;
    logic [15:0] pad_flag_mask;
    logic [15:0] pad_record_kind;
    logic        head_load;
    logic [63:0] head_value;
  } cfg_t;

  typedef struct packed {
    status_t     status;
    logic [30:0] header_offset;
    logic [15:0] header_kind;
    logic [15:0] header_flags;
    logic [31:0] header_size;
    logic [30:0] payload_offset;
    logic [63:0] head_cursor;
    logic [31:0] free_bytes;
    logic        last;
  } res_t;

  typedef struct packed {
    logic valid;
    logic two;
    res_t first;
    res_t second;
  } push_t;

endpackage
`default_nettype wire

>>> hdl/rrr_regs.sv
`default_nettype none
module rrr_regs (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [rrr_pkg::PADDR_W-1:0] paddr,
  input  wire logic [rrr_pkg::PDATA_W-1:0] pwdata,
  output logic      [rrr_pkg::PDATA_W-1:0] prdata,
  output logic                             pready,
  output rrr_pkg::cfg_t                    cfg
);
  import rrr_pkg::*;

  logic [4:0]  capacity_log2_r;
  logic [63:0] start_cursor_r;
  logic [15:0] pad_flag_mask_r;
  logic [15:0] pad_record_kind_r;
  logic        wr_en;
  reg_idx_t    idx;

  assign idx    = reg_idx_t'(paddr[PADDR_W-1:3]);
  assign wr_en  = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_log2_r   <= 5'd16;
      start_cursor_r    <= '0;
      pad_flag_mask_r   <= 16'd1;
      pad_record_kind_r <= 16'hFFFF;
    end else if (wr_en) begin
      unique case (idx)
        REG_CAPACITY_LOG2:   capacity_log2_r   <= pwdata[4:0];
        REG_START_CURSOR:    start_cursor_r    <= pwdata[63:0];
        REG_PAD_FLAG_MASK:   pad_flag_mask_r   <= pwdata[15:0];
        REG_PAD_RECORD_KIND: pad_record_kind_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_CAPACITY_LOG2:   prdata = {59'd0, capacity_log2_r};
      REG_START_CURSOR:    prdata = start_cursor_r;
      REG_PAD_FLAG_MASK:   prdata = {48'd0, pad_flag_mask_r};
      REG_PAD_RECORD_KIND: prdata = {48'd0, pad_record_kind_r};
      default:             prdata = '0;
    endcase
  end

  always_comb begin
    cfg.capacity_log2   = capacity_log2_r;
    cfg.pad_flag_mask   = pad_flag_mask_r;
    cfg.pad_record_kind = pad_record_kind_r;
    cfg.head_load       = wr_en && (idx == REG_START_CURSOR);
    cfg.head_value      = pwdata[63:0];
  end

endmodule
`default_nettype wire

>>> hdl/rrr_alloc.sv
`default_nettype none
module rrr_alloc (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire rrr_pkg::cfg_t cfg,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic          in_kind,
  input  wire logic [15:0]   in_record_kind,
  input  wire logic [15:0]   in_record_flags,
  input  wire logic [31:0]   in_payload_length,
  input  wire logic [63:0]   in_retired_tail,
  input  wire logic          space_ok,
  output rrr_pkg::push_t     push
);
  import rrr_pkg::*;

  logic        s1_valid_r;
  item_kind_t  s1_kind_r;
  logic [15:0] s1_record_kind_r;
  logic [15:0] s1_record_flags_r;
  logic [31:0] s1_payload_r;
  logic [63:0] s1_tail_r;
  logic [63:0] local_head_r;
  logic [63:0] local_head_nxt;

  logic        fire;
  logic [4:0]  lg_eff;
  logic [31:0] cap;
  logic [30:0] mask;
  logic [63:0] in_flight;
  logic [31:0] free_b;
  logic [32:0] total;
  logic        too_large;
  logic [30:0] offset;
  logic [31:0] to_end;
  logic        needs_pad;
  logic [33:0] needed;
  logic        full;
  logic [63:0] head_pad;
  logic [63:0] head_new;
  logic [30:0] rec_offset;
  res_t        zero_res;
  res_t        pad_res;
  res_t        rec_res;

  assign fire     = s1_valid_r && space_ok;
  assign in_ready = !s1_valid_r || space_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_kind_r         <= item_kind_t'(in_kind);
      s1_record_kind_r  <= in_record_kind;
      s1_record_flags_r <= in_record_flags;
      s1_payload_r      <= in_payload_length;
      s1_tail_r         <= in_retired_tail;
    end
  end

  always_comb begin
    lg_eff    = (cfg.capacity_log2 < 5'(MIN_CAP_LOG2)) ? 5'(MIN_CAP_LOG2) : cfg.capacity_log2;
    cap       = 32'd1 << lg_eff;
    mask      = cap[30:0] - 31'd1;
    in_flight = local_head_r - s1_tail_r;
    free_b    = (in_flight >= {32'd0, cap}) ? 32'd0 : cap - in_flight[31:0];
    total     = ({1'b0, s1_payload_r} + 33'(HEADER_BYTES + ALIGN_BYTES - 1))
                & ~33'(ALIGN_BYTES - 1);
    too_large = total > {2'b0, cap[31:1]};
    offset    = local_head_r[30:0] & mask;
    to_end    = cap - {1'b0, offset};
    needs_pad = {1'b0, to_end} < total;
    needed    = needs_pad ? ({2'b0, to_end} + {1'b0, total}) : {1'b0, total};
    full      = {2'b0, free_b} < needed;
    head_pad  = local_head_r + {32'd0, to_end};
    head_new  = local_head_r + {30'd0, needed};
    rec_offset = needs_pad ? 31'd0 : offset;

    zero_res             = '0;
    zero_res.head_cursor = local_head_r;
    zero_res.free_bytes  = free_b;
    zero_res.last        = 1'b1;
    if (s1_kind_r == KIND_PUBLISH) begin
      zero_res.status = ST_PUBLISHED;
    end else if (too_large) begin
      zero_res.status = ST_TOO_LARGE;
    end else begin
      zero_res.status = ST_FULL;
    end

    pad_res.status         = ST_PAD;
    pad_res.header_offset  = offset;
    pad_res.header_kind    = cfg.pad_record_kind;
    pad_res.header_flags   = cfg.pad_flag_mask;
    pad_res.header_size    = to_end;
    pad_res.payload_offset = (offset + 31'(HEADER_BYTES)) & mask;
    pad_res.head_cursor    = head_pad;
    pad_res.free_bytes     = free_b;
    pad_res.last           = 1'b0;

    rec_res.status         = ST_RECORD;
    rec_res.header_offset  = rec_offset;
    rec_res.header_kind    = s1_record_kind_r;
    rec_res.header_flags   = s1_record_flags_r & ~cfg.pad_flag_mask;
    rec_res.header_size    = total[31:0];
    rec_res.payload_offset = (rec_offset + 31'(HEADER_BYTES)) & mask;
    rec_res.head_cursor    = head_new;
    rec_res.free_bytes     = free_b;
    rec_res.last           = 1'b1;

    push.valid     = fire;
    push.two       = 1'b0;
    push.first     = zero_res;
    push.second    = rec_res;
    local_head_nxt = local_head_r;
    if (s1_kind_r == KIND_RESERVE && !too_large && !full) begin
      if (fire) begin
        local_head_nxt = head_new;
      end
      if (needs_pad) begin
        push.two   = 1'b1;
        push.first = pad_res;
      end else begin
        push.first = rec_res;
      end
    end
    if (cfg.head_load) begin
      local_head_nxt = cfg.head_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_head_r <= '0;
    end else begin
      local_head_r <= local_head_nxt;
    end
  end

endmodule
`default_nettype wire

>>> hdl/rrr_resq.sv
`default_nettype none
module rrr_resq (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire rrr_pkg::push_t push,
  output logic                space_ok,
  output logic                out_valid,
  input  wire logic           out_ready,
  output rrr_pkg::res_t       head
);
  import rrr_pkg::*;

  res_t               entry_r [RESQ_DEPTH];
  logic [RESQ_AW-1:0] wr_ptr_r;
  logic [RESQ_AW-1:0] wr_ptr_nxt;
  logic [RESQ_AW-1:0] rd_ptr_r;
  logic [RESQ_AW-1:0] rd_ptr_nxt;
  logic [RESQ_AW:0]   count_r;
  logic [RESQ_AW:0]   count_nxt;
  logic [RESQ_AW:0]   push_n;
  logic               pop;

  assign space_ok  = count_r <= (RESQ_AW+1)'(RESQ_DEPTH - 2);
  assign out_valid = count_r != '0;
  assign head      = entry_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;

  always_comb begin
    push_n = '0;
    if (push.valid) begin
      push_n = push.two ? (RESQ_AW+1)'(2) : (RESQ_AW+1)'(1);
    end
    wr_ptr_nxt = wr_ptr_r + push_n[RESQ_AW-1:0];
    rd_ptr_nxt = pop ? rd_ptr_r + RESQ_AW'(1) : rd_ptr_r;
    count_nxt  = count_r + push_n - (RESQ_AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      entry_r[wr_ptr_r] <= push.first;
      if (push.two) begin
        entry_r[wr_ptr_r + RESQ_AW'(1)] <= push.second;
      end
    end
  end

endmodule
`default_nettype wire

>>> hdl/ring_record_reserve.sv
// Flow: an accepted transaction is registered in the input stage; its results then enter the
// result queue once it has room for two entries, and are offered from the queue head.
// Throughput: one input transaction per cycle while the result queue has room; a wrap gives
// two results, absorbed by the four-entry result queue.
// Reset: synchronous, active low; registers return to their reset values, the local head
// to the start cursor reset value of zero, and the input stage and result queue empty.
`default_nettype none
module ring_record_reserve (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [rrr_pkg::PADDR_W-1:0] paddr,
  input  wire logic [rrr_pkg::PDATA_W-1:0] pwdata,
  output logic      [rrr_pkg::PDATA_W-1:0] prdata,
  output logic                             pready,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic                        in_kind,
  input  wire logic [15:0]                 in_record_kind,
  input  wire logic [15:0]                 in_record_flags,
  input  wire logic [31:0]                 in_payload_length,
  input  wire logic [63:0]                 in_retired_tail,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [2:0]                       out_status,
  output logic [30:0]                      out_header_offset,
  output logic [15:0]                      out_header_kind,
  output logic [15:0]                      out_header_flags,
  output logic [31:0]                      out_header_size,
  output logic [30:0]                      out_payload_offset,
  output logic [63:0]                      out_head_cursor,
  output logic [31:0]                      out_free_bytes,
  output logic                             out_last
);
  import rrr_pkg::*;

  cfg_t  cfg;
  push_t push;
  res_t  head;
  logic  space_ok;

  rrr_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rrr_alloc u_alloc (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_kind           (in_kind),
    .in_record_kind    (in_record_kind),
    .in_record_flags   (in_record_flags),
    .in_payload_length (in_payload_length),
    .in_retired_tail   (in_retired_tail),
    .space_ok          (space_ok),
    .push              (push)
  );

  rrr_resq u_resq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .space_ok  (space_ok),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign out_status         = head.status;
  assign out_header_offset  = head.header_offset;
  assign out_header_kind    = head.header_kind;
  assign out_header_flags   = head.header_flags;
  assign out_header_size    = head.header_size;
  assign out_payload_offset = head.payload_offset;
  assign out_head_cursor    = head.head_cursor;
  assign out_free_bytes     = head.free_bytes;
  assign out_last           = head.last;

endmodule
`default_nettype wire

>>> verif/tb_ring_record_reserve.sv
`timescale 1ns / 100ps
module tb_ring_record_reserve;
  import rrr_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_PRINTED = 50;

  typedef struct {
    item_kind_t  kind;
    logic [15:0] record_kind;
    logic [15:0] record_flags;
    logic [31:0] payload_length;
    logic [63:0] retired_tail;
  } reserve_req_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_kind = 1'b0;
  logic [15:0] in_record_kind = '0;
  logic [15:0] in_record_flags = '0;
  logic [31:0] in_payload_length = '0;
  logic [63:0] in_retired_tail = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [2:0] out_status;
  logic [30:0] out_header_offset;
  logic [15:0] out_header_kind;
  logic [15:0] out_header_flags;
  logic [31:0] out_header_size;
  logic [30:0] out_payload_offset;
  logic [63:0] out_head_cursor;
  logic [31:0] out_free_bytes;
  logic out_last;

  logic [4:0] cfg_cap_log2 = 5'd16;
  logic [15:0] cfg_pad_mask = 16'h0001;
  logic [15:0] cfg_pad_kind = 16'hFFFF;
  logic [63:0] pred_head = '0;
  res_t pending_results[$];

  int send_idle_pct = 0;
  int stall_pct = 0;
  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int publishes = 0;
  int wraps = 0;
  int fulls = 0;
  int oversize = 0;
  int settings = 0;
  int quiet_cycles = 0;

  ring_record_reserve u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_kind           (in_kind),
    .in_record_kind    (in_record_kind),
    .in_record_flags   (in_record_flags),
    .in_payload_length (in_payload_length),
    .in_retired_tail   (in_retired_tail),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_header_offset (out_header_offset),
    .out_header_kind   (out_header_kind),
    .out_header_flags  (out_header_flags),
    .out_header_size   (out_header_size),
    .out_payload_offset(out_payload_offset),
    .out_head_cursor   (out_head_cursor),
    .out_free_bytes    (out_free_bytes),
    .out_last          (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [63:0] ring_bytes();
    logic [4:0] lg;
    lg = (cfg_cap_log2 < MIN_CAP_LOG2) ? 5'(MIN_CAP_LOG2) : cfg_cap_log2;
    return 64'd1 << lg;
  endfunction

  function automatic void predict_placement(input reserve_req_t r);
    logic [63:0] cap;
    logic [63:0] mask;
    logic [63:0] in_flight;
    logic [63:0] freeb;
    logic [63:0] total;
    logic [63:0] offset;
    logic [63:0] to_end;
    logic [63:0] needed;
    logic needs_pad;
    res_t res;
    cap = ring_bytes();
    mask = cap - 64'd1;
    in_flight = pred_head - r.retired_tail;
    freeb = (in_flight >= cap) ? 64'd0 : cap - in_flight;
    res = '0;
    res.head_cursor = pred_head;
    res.free_bytes = freeb[31:0];
    res.last = 1'b1;
    if (r.kind == KIND_PUBLISH) begin
      res.status = ST_PUBLISHED;
      pending_results.push_back(res);
      publishes++;
      return;
    end
    total = (64'(HEADER_BYTES) + 64'(r.payload_length) + 64'(ALIGN_BYTES - 1))
            & ~64'(ALIGN_BYTES - 1);
    offset = pred_head & mask;
    to_end = cap - offset;
    needs_pad = to_end < total;
    needed = needs_pad ? to_end + total : total;
    if (total > (cap >> 1)) begin
      res.status = ST_TOO_LARGE;
      pending_results.push_back(res);
      oversize++;
      return;
    end
    if (freeb < needed) begin
      res.status = ST_FULL;
      pending_results.push_back(res);
      fulls++;
      return;
    end
    if (needs_pad) begin
      pred_head = pred_head + to_end;
      res.status = ST_PAD;
      res.header_offset = offset[30:0];
      res.header_kind = cfg_pad_kind;
      res.header_flags = cfg_pad_mask;
      res.header_size = to_end[31:0];
      res.payload_offset = 31'((offset + 64'(HEADER_BYTES)) & mask);
      res.head_cursor = pred_head;
      res.last = 1'b0;
      pending_results.push_back(res);
      wraps++;
      offset = pred_head & mask;
    end
    pred_head = pred_head + total;
    res.status = ST_RECORD;
    res.header_offset = offset[30:0];
    res.header_kind = r.record_kind;
    res.header_flags = r.record_flags & ~cfg_pad_mask;
    res.header_size = total[31:0];
    res.payload_offset = 31'((offset + 64'(HEADER_BYTES)) & mask);
    res.head_cursor = pred_head;
    res.last = 1'b1;
    pending_results.push_back(res);
  endfunction

  function automatic reserve_req_t make_request();
    reserve_req_t r;
    logic [63:0] cap;
    int unsigned half_max;
    cap = ring_bytes();
    half_max = 32'(cap >> 1) - 32'd8;
    r.kind = ($urandom_range(0, 9) == 0) ? KIND_PUBLISH : KIND_RESERVE;
    r.record_kind = 16'($urandom);
    r.record_flags = 16'($urandom);
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: r.payload_length = $urandom_range(0, (half_max < 255) ? half_max : 255);
      5, 6: r.payload_length = $urandom_range(0, half_max);
      7: r.payload_length = half_max - 8 + $urandom_range(0, 16);
      8: begin
        case ($urandom_range(0, 2))
          0: r.payload_length = 32'd0;
          1: r.payload_length = 32'hFFFF_FFFF;
          default: r.payload_length = $urandom;
        endcase
      end
      default: r.payload_length = $urandom_range(0, 7);
    endcase
    case ($urandom_range(0, 9))
      0, 1, 2, 3: r.retired_tail = pred_head - 64'($urandom_range(0, 32'(cap)));
      4, 5: r.retired_tail = pred_head;
      6: r.retired_tail = pred_head - cap;
      7: r.retired_tail = pred_head - cap + 64'($urandom_range(0, 64));
      8: r.retired_tail = {$urandom, $urandom};
      default: r.retired_tail = pred_head + 64'($urandom_range(1, 64));
    endcase
    return r;
  endfunction

  task automatic note_mismatch(input string field, input logic [63:0] got,
                               input logic [63:0] want);
    errors++;
    if (errors <= MAX_PRINTED) begin
      $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $time, field, got, want);
    end
  endtask

  task automatic send_request(input reserve_req_t r);
    int gap;
    gap = 0;
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct && gap < 200) begin
      gap++;
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= r.kind;
    in_record_kind <= r.record_kind;
    in_record_flags <= r.record_flags;
    in_payload_length <= r.payload_length;
    in_retired_tail <= r.retired_tail;
    do @(posedge clk); while (!in_ready);
    predict_placement(r);
    items_sent++;
  endtask

  task automatic send_behind_head(input item_kind_t kind, input logic [15:0] rkind,
                                  input logic [15:0] flags, input logic [31:0] payload,
                                  input logic [63:0] back);
    reserve_req_t r;
    r.kind = kind;
    r.record_kind = rkind;
    r.record_flags = flags;
    r.payload_length = payload;
    r.retired_tail = pred_head - back;
    send_request(r);
  endtask

  task automatic wait_until_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [63:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_CAPACITY_LOG2: cfg_cap_log2 = value[4:0];
      REG_START_CURSOR: pred_head = value;
      REG_PAD_FLAG_MASK: cfg_pad_mask = value[15:0];
      REG_PAD_RECORD_KIND: cfg_pad_kind = value[15:0];
      default: ;
    endcase
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_setting(input logic [4:0] lg, input logic [63:0] start,
                               input logic [15:0] mask, input logic [15:0] pad_kind);
    wait_until_drained();
    write_reg(REG_CAPACITY_LOG2, 64'(lg));
    write_reg(REG_START_CURSOR, start);
    write_reg(REG_PAD_FLAG_MASK, 64'(mask));
    write_reg(REG_PAD_RECORD_KIND, 64'(pad_kind));
    settings++;
  endtask

  task automatic test_directed_cases();
    apply_setting(5'd6, 64'd0, 16'h0001, 16'h0000);
    send_behind_head(KIND_PUBLISH, 16'h0000, 16'h0000, 32'd0, 64'd0);
    send_behind_head(KIND_RESERVE, 16'h0000, 16'h0000, 32'd0, 64'd0);
    send_behind_head(KIND_RESERVE, 16'hFFFF, 16'hFFFF, 32'd24, 64'd8);
    send_behind_head(KIND_RESERVE, 16'h1234, 16'h0001, 32'd25, 64'd0);
    send_behind_head(KIND_RESERVE, 16'h0000, 16'h0000, 32'hFFFF_FFFF, 64'd0);
    send_behind_head(KIND_RESERVE, 16'h5A5A, 16'hA5A5, 32'd16, 64'd40);
    send_behind_head(KIND_RESERVE, 16'h0001, 16'h0002, 32'd0, 64'd64);
    send_behind_head(KIND_RESERVE, 16'h0001, 16'h0002, 32'd0, 64'd100);
    send_behind_head(KIND_RESERVE, 16'h0003, 16'h0004, 32'd16, 64'd0);
    send_behind_head(KIND_RESERVE, 16'h0005, 16'h0006, 32'd8, 64'd0);
    send_behind_head(KIND_RESERVE, 16'h0007, 16'h0008, 32'd24, 64'd24);
    send_behind_head(KIND_RESERVE, 16'h0009, 16'hFFFF, 32'd24, 64'd8);
    send_behind_head(KIND_RESERVE, 16'h000A, 16'h0000, 32'd0, -64'sd8);
    send_behind_head(KIND_PUBLISH, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, -64'sd8);
    apply_setting(5'd3, 64'hFFFF_FFFF_FFFF_FFC5, 16'h8000, 16'hFFFF);
    send_behind_head(KIND_RESERVE, 16'h000B, 16'hFFFF, 32'd0, 64'd0);
    send_behind_head(KIND_RESERVE, 16'h000C, 16'h8001, 32'd24, 64'd0);
    send_behind_head(KIND_RESERVE, 16'h000D, 16'h7FFF, 32'd8, 64'd0);
    send_behind_head(KIND_RESERVE, 16'h000E, 16'hFFFF, 32'd0, 64'd0);
    send_behind_head(KIND_PUBLISH, 16'h0000, 16'h0000, 32'd0, 64'd0);
  endtask

  task automatic test_capacity_extremes();
    apply_setting(5'd31, 64'd0, 16'hFFFF, 16'h0000);
    send_behind_head(KIND_PUBLISH, 16'h0000, 16'h0000, 32'd0, 64'd0);
    send_behind_head(KIND_RESERVE, 16'h0001, 16'hFFFF, 32'h7FFF_FFF8, 64'd0);
    send_behind_head(KIND_RESERVE, 16'h0002, 16'h0000, 32'h7FFF_FFF9, 64'd0);
    send_behind_head(KIND_RESERVE, 16'h0003, 16'h0000, 32'h7FFF_FFF8, 64'h8000_0000);
    send_behind_head(KIND_RESERVE, 16'h0003, 16'h0000, 32'h7FFF_FFF8, 64'd0);
    apply_setting(5'd31, 64'h0000_0000_7FFF_FFF8, 16'h0001, 16'hFFFF);
    send_behind_head(KIND_RESERVE, 16'h0004, 16'h0001, 32'd16, 64'd0);
    send_behind_head(KIND_RESERVE, 16'h0005, 16'h0003, 32'd0, 64'd7);
    apply_setting(5'd0, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 16'h8000);
    send_behind_head(KIND_RESERVE, 16'h0006, 16'hFFFF, 32'd0, 64'd0);
    send_behind_head(KIND_RESERVE, 16'h0007, 16'h0000, 32'd23, 64'd0);
  endtask

  task automatic test_random_traffic();
    int idle_mix[4];
    int stall_mix[4];
    int sel;
    logic [4:0] lg;
    logic [63:0] start;
    reserve_req_t r;
    idle_mix = '{0, 79, 0, 9};
    stall_mix = '{0, 0, 79, 9};
    for (int p = 0; p < 4; p++) begin
      for (int half = 0; half < 2; half++) begin
        sel = $urandom_range(0, 19);
        if (sel < 12) begin
          lg = 5'($urandom_range(6, 9));
        end else if (sel < 15) begin
          lg = 5'($urandom_range(10, 16));
        end else if (sel < 17) begin
          lg = 5'($urandom_range(0, 5));
        end else begin
          lg = 5'($urandom_range(17, 31));
        end
        case ($urandom_range(0, 3))
          0, 1: start = {$urandom, $urandom};
          2: start = {$urandom, $urandom} & ~64'd7;
          default: start = ~64'($urandom_range(0, 255));
        endcase
        apply_setting(lg, start,
                      ($urandom_range(0, 3) == 0) ? 16'h0001 : 16'($urandom_range(1, 65535)),
                      16'($urandom));
        send_idle_pct = idle_mix[p];
        stall_pct = stall_mix[p];
        repeat (75) begin
          r = make_request();
          send_request(r);
        end
      end
    end
    send_idle_pct = 0;
    stall_pct = 0;
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin : result_check
    res_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        note_mismatch("result with no transaction pending", out_head_cursor, 64'd0);
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status) note_mismatch("status", out_status, want.status);
        if (out_header_offset !== want.header_offset)
          note_mismatch("header_offset", out_header_offset, want.header_offset);
        if (out_header_kind !== want.header_kind)
          note_mismatch("header_kind", out_header_kind, want.header_kind);
        if (out_header_flags !== want.header_flags)
          note_mismatch("header_flags", out_header_flags, want.header_flags);
        if (out_header_size !== want.header_size)
          note_mismatch("header_size", out_header_size, want.header_size);
        if (out_payload_offset !== want.payload_offset)
          note_mismatch("payload_offset", out_payload_offset, want.payload_offset);
        if (out_head_cursor !== want.head_cursor)
          note_mismatch("head_cursor", out_head_cursor, want.head_cursor);
        if (out_free_bytes !== want.free_bytes)
          note_mismatch("free_bytes", out_free_bytes, want.free_bytes);
        if (out_last !== want.last) note_mismatch("last", out_last, want.last);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no transaction for %0d cycles, %0d results outstanding",
               quiet_cycles, pending_results.size());
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_cases();
    test_capacity_extremes();
    test_random_traffic();
    wait_until_drained();
    repeat (8) @(posedge clk);
    $display("Covered %0d transactions (%0d publishes) over %0d register settings.",
             items_sent, publishes, settings);
    $display("Checked %0d results: %0d wraps, %0d full, %0d oversize; %0d mismatches.",
             results_seen, wraps, fulls, oversize, errors);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
